### rtl/sbmq_pkg.sv
// Shared types and constants of the shared-buffer multi-queue block.
`default_nettype none
package sbmq_pkg;

	typedef enum logic [1:0] {
		OP_ENQ     = 2'd0,
		OP_DEQ     = 2'd1,
		OP_INSPECT = 2'd2
	} op_t;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_SLOT = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_ENQ_LINK,
		S_ENQ_COMMIT,
		S_DEQ_COMMIT,
		S_FRONT,
		S_BACK,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       capture;
		logic       load_ptr;
		logic [1:0] status;
		logic       enq_start;
		logic       deq_start;
		logic       link_tail;
		logic       enq_commit;
		logic       deq_commit;
		logic       rd_front;
		logic       rd_back;
		logic       finish;
	} ctrl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_enq;
		logic is_deq;
		logic qok;
		logic q_nonempty;
		logic free_avail;
		logic cur_nonempty;
		logic head_ends;
	} stat_t;

endpackage
`default_nettype wire

### rtl/sbmq_ctrl.sv
// Controller state machine that sequences one queue operation.
`default_nettype none
module sbmq_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire sbmq_pkg::stat_t stat,
	output sbmq_pkg::ctrl_t      cmd,
	output logic                 busy,
	output logic                 done
);
	import sbmq_pkg::*;

	state_t state_q;
	state_t state_nx;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			done_q  <= cmd.finish;
		end
	end

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_nx    = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.load_ptr = 1'b1;
				state_nx     = S_FRONT;
				if (stat.is_enq) begin
					if (stat.qok && stat.free_avail) begin
						cmd.status    = STAT_OK;
						cmd.enq_start = 1'b1;
						state_nx      = S_ENQ_LINK;
					end else begin
						cmd.status = STAT_NO_SLOT;
					end
				end else if (stat.is_deq) begin
					if (stat.qok && stat.q_nonempty) begin
						cmd.status    = STAT_OK;
						cmd.deq_start = 1'b1;
						state_nx      = S_DEQ_COMMIT;
					end else begin
						cmd.status = STAT_EMPTY;
					end
				end else begin
					cmd.status = STAT_OK;
				end
			end
			S_ENQ_LINK: begin
				// Only a queue that already holds slots has a tail to link from.
				cmd.link_tail = stat.cur_nonempty;
				state_nx      = S_ENQ_COMMIT;
			end
			S_ENQ_COMMIT: begin
				cmd.enq_commit = 1'b1;
				state_nx       = S_FRONT;
			end
			S_DEQ_COMMIT: begin
				cmd.deq_commit = 1'b1;
				state_nx       = S_FRONT;
			end
			S_FRONT: begin
				cmd.rd_front = 1'b1;
				state_nx     = S_BACK;
			end
			S_BACK: begin
				cmd.rd_back = 1'b1;
				state_nx    = S_DONE;
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_nx   = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule
`default_nettype wire

### rtl/sbmq_datapath.sv
// Datapath: slot store, link table, queue pointers and free list.
`default_nettype none
module sbmq_datapath #(
	parameter int NUM_QUEUES = 8,
	parameter int NUM_SLOTS  = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire sbmq_pkg::ctrl_t    cmd,
	output sbmq_pkg::stat_t         stat,
	input  wire logic [1:0]         op,
	input  wire logic [2:0]         queue_id,
	input  wire logic signed [31:0] data_in,
	output logic [1:0]              status,
	output logic signed [31:0]      popped_value,
	output logic signed [31:0]      front_value,
	output logic signed [31:0]      back_value,
	output logic                    is_empty
);
	import sbmq_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int PW = $clog2(NUM_SLOTS + 1);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [PW-1:0] LINK_NULL = PW'(NUM_SLOTS);

	logic [31:0]   data_mem [NUM_SLOTS];
	logic [PW-1:0] link_mem [NUM_SLOTS];
	logic [SW-1:0] head_mem [NUM_QUEUES];
	logic [SW-1:0] tail_mem [NUM_QUEUES];

	logic [NUM_QUEUES-1:0] ne_vec_q;
	logic [PW-1:0]         free_head_q;
	logic [PW-1:0]         fresh_q;

	logic [1:0]    op_q;
	logic [QW-1:0] qidx_q;
	logic          qok_q;
	logic [31:0]   din_q;
	logic [SW-1:0] head_rd_q;
	logic [SW-1:0] tail_rd_q;
	logic          ne_rd_q;
	logic [SW-1:0] head_q;
	logic [SW-1:0] tail_q;
	logic          ne_q;
	logic [SW-1:0] slot_q;
	logic [1:0]    status_q;
	logic [31:0]   popped_q;
	logic [31:0]   front_q;
	logic [31:0]   data_rd_q;
	logic [PW-1:0] link_rd_q;
	logic          link_fresh_q;
	logic [PW-1:0] link_plus_q;

	logic [QW-1:0] qidx_in;
	logic          qok_in;
	logic [PW-1:0] link_val;
	logic          link_re;
	logic [SW-1:0] link_ra;
	logic          link_we;
	logic [SW-1:0] link_wa;
	logic [PW-1:0] link_wd;
	logic          data_re;
	logic [SW-1:0] data_ra;
	logic          is_enq;

	assign qidx_in = QW'(queue_id);
	assign qok_in  = (32'(queue_id) < NUM_QUEUES);
	assign is_enq  = (op_q == OP_ENQ);

	// Slots at or beyond the fresh mark were never relinked and still point to the next slot.
	assign link_val = link_fresh_q ? link_plus_q : link_rd_q;

	assign stat.is_enq       = is_enq;
	assign stat.is_deq       = (op_q == OP_DEQ);
	assign stat.qok          = qok_q;
	assign stat.q_nonempty   = ne_rd_q;
	assign stat.free_avail   = (free_head_q < LINK_NULL);
	assign stat.cur_nonempty = ne_q;
	assign stat.head_ends    = (link_val >= LINK_NULL);

	// Queue pointer memories; the nonempty flags stand in for their reset.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			head_rd_q <= head_mem[qidx_in];
			tail_rd_q <= tail_mem[qidx_in];
		end
		if (cmd.enq_commit) begin
			tail_mem[qidx_q] <= slot_q;
			if (!ne_q)
				head_mem[qidx_q] <= slot_q;
		end
		if (cmd.deq_commit && !stat.head_ends)
			head_mem[qidx_q] <= link_val[SW-1:0];
	end

	// Link table.
	always_comb begin
		link_re = cmd.enq_start || cmd.deq_start;
		link_ra = is_enq ? free_head_q[SW-1:0] : head_rd_q;
		link_we = cmd.link_tail || cmd.enq_commit || cmd.deq_commit;
		link_wa = cmd.link_tail ? tail_q : slot_q;
		link_wd = LINK_NULL;
		priority if (cmd.link_tail)
			link_wd = PW'(slot_q);
		else if (cmd.deq_commit)
			link_wd = free_head_q;
		else
			link_wd = LINK_NULL;
	end

	always_ff @(posedge clk) begin
		if (link_we)
			link_mem[link_wa] <= link_wd;
		if (link_re) begin
			link_rd_q    <= link_mem[link_ra];
			link_fresh_q <= (PW'(link_ra) >= fresh_q);
			link_plus_q  <= PW'(link_ra) + PW'(1);
		end
	end

	// Slot data store.
	always_comb begin
		data_re = cmd.deq_start || cmd.rd_front || cmd.rd_back;
		priority if (cmd.deq_start)
			data_ra = head_rd_q;
		else if (cmd.rd_front)
			data_ra = head_q;
		else
			data_ra = tail_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.enq_start)
			data_mem[free_head_q[SW-1:0]] <= din_q;
		if (data_re)
			data_rd_q <= data_mem[data_ra];
	end

	// Control state: nonempty flags, free list head and fresh mark.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_vec_q    <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
			ne_rd_q     <= 1'b0;
		end else begin
			if (cmd.capture)
				ne_rd_q <= qok_in ? ne_vec_q[qidx_in] : 1'b0;
			if (cmd.enq_commit) begin
				ne_vec_q[qidx_q] <= 1'b1;
				free_head_q      <= link_val;
				if (PW'(slot_q) >= fresh_q)
					fresh_q <= fresh_q + PW'(1);
			end
			if (cmd.deq_commit) begin
				free_head_q <= PW'(slot_q);
				if (stat.head_ends)
					ne_vec_q[qidx_q] <= 1'b0;
			end
		end
	end

	// Working registers of the current operation and the result.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			qidx_q <= qidx_in;
			qok_q  <= qok_in;
			din_q  <= data_in;
		end
		if (cmd.load_ptr) begin
			head_q   <= head_rd_q;
			tail_q   <= tail_rd_q;
			ne_q     <= ne_rd_q;
			status_q <= cmd.status;
			popped_q <= '0;
		end
		if (cmd.enq_start || cmd.deq_start)
			slot_q <= cmd.enq_start ? free_head_q[SW-1:0] : head_rd_q;
		if (cmd.enq_commit) begin
			tail_q <= slot_q;
			ne_q   <= 1'b1;
			if (!ne_q)
				head_q <= slot_q;
		end
		if (cmd.deq_commit) begin
			popped_q <= data_rd_q;
			if (stat.head_ends)
				ne_q <= 1'b0;
			else
				head_q <= link_val[SW-1:0];
		end
		if (cmd.rd_back)
			front_q <= ne_q ? data_rd_q : '0;
		if (cmd.finish) begin
			status       <= status_q;
			popped_value <= popped_q;
			front_value  <= front_q;
			back_value   <= ne_q ? data_rd_q : '0;
			is_empty     <= !ne_q;
		end
	end

endmodule
`default_nettype wire

### rtl/shared_buffer_multi_queue.sv
// An operation steps through evaluate, then link and commit for an enqueue that succeeds
// or commit for a dequeue that succeeds, then the front and back reads and the result.
// A new operation is taken only once the last is through. Slot store and link table
// each have one read port; head, front and back reads use the slot store's in turn.
// Reset clears all queues and chains every slot into the free list at once; no sweep.
// Each result is shown for one cycle under done; the receiver cannot stall it.
`default_nettype none
module shared_buffer_multi_queue #(
	parameter int NUM_QUEUES = 8,
	parameter int NUM_SLOTS  = 256
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         op,
	input  wire logic [2:0]         queue_id,
	input  wire logic signed [31:0] data_in,
	output logic                    done,
	output logic [1:0]              status,
	output logic signed [31:0]      popped_value,
	output logic signed [31:0]      front_value,
	output logic signed [31:0]      back_value,
	output logic                    is_empty
);
	import sbmq_pkg::*;

	ctrl_t cmd;
	stat_t stat;
	logic  start_ok;

	// Start is only taken while the block is free.
	assign start_ok = start && !busy;

	sbmq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_ok),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sbmq_datapath #(
		.NUM_QUEUES (NUM_QUEUES),
		.NUM_SLOTS  (NUM_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.op           (op),
		.queue_id     (queue_id),
		.data_in      (data_in),
		.status       (status),
		.popped_value (popped_value),
		.front_value  (front_value),
		.back_value   (back_value),
		.is_empty     (is_empty)
	);

endmodule
`default_nettype wire
